### rtl/thumb_data_processing_execute_assert.svh
// Assertion macros used by the checker of the Thumb execute block.
`ifndef THUMB_DATA_PROCESSING_EXECUTE_ASSERT_SVH
`define THUMB_DATA_PROCESSING_EXECUTE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDPE_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thumb execute check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define TDPE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thumb execute check failed in the following cycle");

`endif

### rtl/tdpe_pkg.sv
// Types, codes and operand decode shared by the Thumb execute block.
`default_nettype none

package tdpe_pkg;

    localparam int XLEN     = 32;
    localparam int IDX_W    = 4;
    localparam int NUM_REGS = 16;
    localparam logic [IDX_W-1:0] PC_IDX = 4'd15;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDEF     = 2'd1,
        STATUS_NOT_THUMB = 2'd2
    } status_t;

    // Top three bits of the instruction.
    localparam logic [2:0] GRP_SHIFT  = 3'd0;
    localparam logic [2:0] GRP_IMM8   = 3'd1;
    localparam logic [2:0] GRP_ALU_HI = 3'd2;

    // Bits 12:10 within the ALU and hi-register group.
    localparam logic [2:0] SUB_ALU = 3'd0;
    localparam logic [2:0] SUB_HI  = 3'd1;

    localparam logic [1:0] SH_LSL    = 2'd0;
    localparam logic [1:0] SH_LSR    = 2'd1;
    localparam logic [1:0] SH_ASR    = 2'd2;
    localparam logic [1:0] SH_ADDSUB = 2'd3;

    localparam logic [1:0] IMM_MOV = 2'd0;
    localparam logic [1:0] IMM_CMP = 2'd1;
    localparam logic [1:0] IMM_ADD = 2'd2;
    localparam logic [1:0] IMM_SUB = 2'd3;

    localparam logic [3:0] ALU_AND = 4'd0;
    localparam logic [3:0] ALU_EOR = 4'd1;
    localparam logic [3:0] ALU_LSL = 4'd2;
    localparam logic [3:0] ALU_LSR = 4'd3;
    localparam logic [3:0] ALU_NEG = 4'd9;
    localparam logic [3:0] ALU_ORR = 4'd12;
    localparam logic [3:0] ALU_BIC = 4'd14;
    localparam logic [3:0] ALU_MVN = 4'd15;

    localparam logic [1:0] HI_ADD = 2'd0;
    localparam logic [1:0] HI_MOV = 2'd2;
    localparam logic [1:0] HI_BX  = 2'd3;

    typedef struct packed {
        logic            kind;
        logic [15:0]     instruction;
        logic [IDX_W-1:0] load_index;
        logic [XLEN-1:0] load_value;
    } item_t;

    typedef struct packed {
        logic [XLEN-1:0]  next_pc;
        logic             reg_written;
        logic [IDX_W-1:0] dest_index;
        logic [XLEN-1:0]  dest_value;
        logic             thumb;
        status_t          status;
        logic             ram_we;
    } result_t;

    // Register read on the first operand port.
    function automatic logic [IDX_W-1:0] opnd_a_idx(input logic [15:0] ins);
        logic [IDX_W-1:0] idx;
        idx = {1'b0, ins[2:0]};
        if (ins[15:13] == GRP_SHIFT) begin
            idx = {1'b0, ins[5:3]};
        end else if (ins[15:13] == GRP_IMM8) begin
            idx = {1'b0, ins[10:8]};
        end else if (ins[12:10] == SUB_HI) begin
            idx = {ins[7], ins[2:0]};
        end
        return idx;
    endfunction

    // Register read on the second operand port.
    function automatic logic [IDX_W-1:0] opnd_b_idx(input logic [15:0] ins);
        logic [IDX_W-1:0] idx;
        idx = {1'b0, ins[5:3]};
        if (ins[15:13] == GRP_SHIFT) begin
            idx = {1'b0, ins[8:6]};
        end else if (ins[12:10] == SUB_HI) begin
            idx = {ins[6], ins[5:3]};
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### rtl/thumb_data_processing_execute.sv
// Top level of the Thumb register-to-register execute block.
//
//   Channel  Direction  Handshake               Words
//   in       to block   in_valid / in_stall     kind, instruction, load_index, load_value
//   out      from block out_valid / out_stall   next_pc, reg_written, dest_index,
//                                               dest_value, in_thumb, status
//
// One word is taken in every cycle unless in_stall is high; it passes the input register, then
// the output register. Register reads happen from the RAM as a word is accepted, and write-back
// happens as a word moves to the output register; a write-back during a read is forwarded.
// Reset clears the register file through per-entry valid bits and sets Thumb mode at once.
// A stalled output holds its word while the next word waits in the input register.
`default_nettype none

module thumb_data_processing_execute (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [15:0] instruction,
    input  wire logic [3:0]  load_index,
    input  wire logic [31:0] load_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      next_pc,
    output logic             reg_written,
    output logic [3:0]       dest_index,
    output logic [31:0]      dest_value,
    output logic             in_thumb,
    output logic [1:0]       status
);

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    tdpe_pkg::item_t         item_reg;
    logic [3:0]              a_idx_reg;
    logic [3:0]              b_idx_reg;
    logic                    a_fwd_reg;
    logic                    a_fwd_next;
    logic                    b_fwd_reg;
    logic                    b_fwd_next;
    logic                    a_ok_reg;
    logic                    b_ok_reg;
    logic [31:0]             fwd_val_reg;
    logic [31:0]             pc_reg;
    logic                    thumb_reg;
    logic [15:0]             vld_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    tdpe_pkg::result_t       out_res_reg;

    logic                    accept;
    logic                    s1_adv;
    logic                    wb_en;
    logic [3:0]              a_idx_in;
    logic [3:0]              b_idx_in;
    logic [31:0]             ram_a;
    logic [31:0]             ram_b;
    logic [31:0]             opnd_a;
    logic [31:0]             opnd_b;
    tdpe_pkg::result_t       res;

    assign a_idx_in = tdpe_pkg::opnd_a_idx(instruction);
    assign b_idx_in = tdpe_pkg::opnd_b_idx(instruction);

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;
    assign wb_en    = s1_adv && res.ram_we;

    assign a_fwd_next = wb_en && (res.dest_index == a_idx_in);
    assign b_fwd_next = wb_en && (res.dest_index == b_idx_in);

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    tdpe_ram #(
        .WIDTH (tdpe_pkg::XLEN),
        .DEPTH (tdpe_pkg::NUM_REGS)
    ) u_regfile (
        .clk     (clk),
        .we      (wb_en),
        .waddr   (res.dest_index),
        .wdata   (res.dest_value),
        .re      (accept),
        .raddr_a (a_idx_in),
        .raddr_b (b_idx_in),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    always_comb
    begin
        if (a_idx_reg == tdpe_pkg::PC_IDX)
        begin
            opnd_a = pc_reg;
        end
        else if (a_fwd_reg)
        begin
            opnd_a = fwd_val_reg;
        end
        else
        begin
            opnd_a = a_ok_reg ? ram_a : 32'd0;
        end

        if (b_idx_reg == tdpe_pkg::PC_IDX)
        begin
            opnd_b = pc_reg;
        end
        else if (b_fwd_reg)
        begin
            opnd_b = fwd_val_reg;
        end
        else
        begin
            opnd_b = b_ok_reg ? ram_b : 32'd0;
        end
    end

    tdpe_exec u_exec (
        .item   (item_reg),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .pc     (pc_reg),
        .thumb  (thumb_reg),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            thumb_reg     <= 1'b1;
            vld_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                pc_reg    <= res.next_pc;
                thumb_reg <= res.thumb;
            end
            if (wb_en)
            begin
                vld_reg[res.dest_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind        <= kind;
            item_reg.instruction <= instruction;
            item_reg.load_index  <= load_index;
            item_reg.load_value  <= load_value;
            a_idx_reg            <= a_idx_in;
            b_idx_reg            <= b_idx_in;
            a_fwd_reg            <= a_fwd_next;
            b_fwd_reg            <= b_fwd_next;
            a_ok_reg             <= vld_reg[a_idx_in];
            b_ok_reg             <= vld_reg[b_idx_in];
            fwd_val_reg          <= res.dest_value;
        end
        if (s1_adv)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = out_res_reg.next_pc;
    assign reg_written = out_res_reg.reg_written;
    assign dest_index  = out_res_reg.dest_index;
    assign dest_value  = out_res_reg.dest_value;
    assign in_thumb    = out_res_reg.thumb;
    assign status      = out_res_reg.status;

endmodule

`default_nettype wire

### rtl/tdpe_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module tdpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem_reg[raddr_a];
            rdata_b <= mem_reg[raddr_b];
        end
    end

endmodule

`default_nettype wire

### rtl/tdpe_exec.sv
// Decode and execute of one word against its operands, PC and mode.
`default_nettype none

module tdpe_exec (
    input  wire tdpe_pkg::item_t    item,
    input  wire logic [31:0]        opnd_a,
    input  wire logic [31:0]        opnd_b,
    input  wire logic [31:0]        pc,
    input  wire logic               thumb,
    output tdpe_pkg::result_t       res
);

    always_comb
    begin
        logic [15:0]       ins;
        logic [2:0]        grp;
        logic [1:0]        op2;
        logic [4:0]        imm5;
        logic [7:0]        amt8;
        logic [31:0]       addend;
        logic [31:0]       dv;
        logic [3:0]        di;
        logic              wr;
        logic              bx;
        tdpe_pkg::status_t st;

        ins    = item.instruction;
        grp    = ins[15:13];
        op2    = ins[12:11];
        imm5   = ins[10:6];
        amt8   = opnd_b[7:0];
        addend = ins[10] ? {29'd0, ins[8:6]} : opnd_b;
        dv     = '0;
        di     = '0;
        wr     = 1'b0;
        bx     = 1'b0;
        st     = tdpe_pkg::STATUS_OK;

        res.next_pc = pc;
        res.thumb   = thumb;
        res.ram_we  = 1'b0;

        if (item.kind)
        begin
            wr = 1'b1;
            di = item.load_index;
            dv = item.load_value;
            if (di == tdpe_pkg::PC_IDX)
            begin
                res.next_pc = dv;
            end
            else
            begin
                res.ram_we = 1'b1;
            end
        end
        else if (!thumb)
        begin
            st = tdpe_pkg::STATUS_NOT_THUMB;
        end
        else
        begin
            if (grp == tdpe_pkg::GRP_SHIFT)
            begin
                wr = 1'b1;
                di = {1'b0, ins[2:0]};
                unique case (op2)
                    tdpe_pkg::SH_LSL: dv = opnd_a << imm5;
                    tdpe_pkg::SH_LSR: dv = (imm5 == 5'd0) ? 32'd0 : (opnd_a >> imm5);
                    tdpe_pkg::SH_ASR: dv = (imm5 == 5'd0) ? {32{opnd_a[31]}}
                                                          : $unsigned($signed(opnd_a) >>> imm5);
                    tdpe_pkg::SH_ADDSUB: dv = ins[9] ? (opnd_a - addend) : (opnd_a + addend);
                    default: dv = '0;
                endcase
            end
            else if (grp == tdpe_pkg::GRP_IMM8)
            begin
                di = {1'b0, ins[10:8]};
                wr = (op2 != tdpe_pkg::IMM_CMP);
                unique case (op2)
                    tdpe_pkg::IMM_MOV: dv = {24'd0, ins[7:0]};
                    tdpe_pkg::IMM_ADD: dv = opnd_a + {24'd0, ins[7:0]};
                    tdpe_pkg::IMM_SUB: dv = opnd_a - {24'd0, ins[7:0]};
                    default:           dv = '0;
                endcase
            end
            else if (grp == tdpe_pkg::GRP_ALU_HI && ins[12:10] == tdpe_pkg::SUB_ALU)
            begin
                wr = 1'b1;
                di = {1'b0, ins[2:0]};
                unique case (ins[9:6])
                    tdpe_pkg::ALU_AND: dv = opnd_a & opnd_b;
                    tdpe_pkg::ALU_EOR: dv = opnd_a ^ opnd_b;
                    tdpe_pkg::ALU_LSL: dv = (amt8 >= 8'd32) ? 32'd0 : (opnd_a << amt8[4:0]);
                    tdpe_pkg::ALU_LSR: dv = (amt8 >= 8'd32) ? 32'd0 : (opnd_a >> amt8[4:0]);
                    tdpe_pkg::ALU_NEG: dv = 32'd0 - opnd_b;
                    tdpe_pkg::ALU_ORR: dv = opnd_a | opnd_b;
                    tdpe_pkg::ALU_BIC: dv = opnd_a & ~opnd_b;
                    tdpe_pkg::ALU_MVN: dv = ~opnd_b;
                    default:           st = tdpe_pkg::STATUS_UNDEF;
                endcase
            end
            else if (grp == tdpe_pkg::GRP_ALU_HI && ins[12:10] == tdpe_pkg::SUB_HI)
            begin
                di = {ins[7], ins[2:0]};
                unique case (ins[9:8])
                    tdpe_pkg::HI_ADD:
                    begin
                        wr = 1'b1;
                        dv = opnd_a + opnd_b;
                    end
                    tdpe_pkg::HI_MOV:
                    begin
                        wr = 1'b1;
                        dv = opnd_b;
                    end
                    tdpe_pkg::HI_BX:   bx = 1'b1;
                    default:           st = tdpe_pkg::STATUS_UNDEF;
                endcase
            end
            else
            begin
                st = tdpe_pkg::STATUS_UNDEF;
            end

            if (st != tdpe_pkg::STATUS_OK)
            begin
                wr = 1'b0;
            end
            else if (bx)
            begin
                wr          = 1'b0;
                res.thumb   = opnd_b[0];
                res.next_pc = {opnd_b[31:1], 1'b0};
            end
            else if (wr && di == tdpe_pkg::PC_IDX)
            begin
                dv[0]       = 1'b0;
                res.next_pc = dv;
            end
            else
            begin
                res.next_pc = pc + 32'd2;
                res.ram_we  = wr;
            end
        end

        if (!wr)
        begin
            di = '0;
            dv = '0;
        end

        res.reg_written = wr;
        res.dest_index  = di;
        res.dest_value  = dv;
        res.status      = st;
    end

endmodule

`default_nettype wire

### rtl/tdpe_checker.sv
// Port-level checks of the Thumb execute block, bound to its top level.
`default_nettype none

`include "thumb_data_processing_execute_assert.svh"

module tdpe_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] next_pc,
    input wire logic        reg_written,
    input wire logic [3:0]  dest_index,
    input wire logic [31:0] dest_value,
    input wire logic        in_thumb,
    input wire logic [1:0]  status
);

    `TDPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(next_pc) && $stable(dest_value) && $stable(status))
    `TDPE_ASSERT_SAME(a_write_ok, out_valid && reg_written, status == tdpe_pkg::STATUS_OK)
    `TDPE_ASSERT_SAME(a_no_write_zero, out_valid && !reg_written, dest_index == 4'd0 && dest_value == 32'd0)
    `TDPE_ASSERT_SAME(a_not_thumb_mode, out_valid && status == tdpe_pkg::STATUS_NOT_THUMB, !in_thumb)
    `TDPE_ASSERT_NEXT(a_mode_sticky, out_valid && !in_thumb, !in_thumb)

endmodule

bind thumb_data_processing_execute tdpe_checker u_tdpe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .next_pc     (next_pc),
    .reg_written (reg_written),
    .dest_index  (dest_index),
    .dest_value  (dest_value),
    .in_thumb    (in_thumb),
    .status      (status)
);

`default_nettype wire

### test/thumb_data_processing_execute_test.sv
// Self-checking testbench for the Thumb register-to-register execute block.
`timescale 1ns / 100ps

module thumb_data_processing_execute_test;

    import tdpe_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX  = 10;

    localparam logic [3:0] ALU_ASR        = 4'd4;
    localparam logic [1:0] HI_CMP         = 2'd1;
    localparam logic [2:0] GRP_LOAD_STORE = 3'd3;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [3:0]  dest_index;
        logic [31:0] dest_value;
        logic        thumb;
        status_t     status;
    } exec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [15:0] instruction = 16'd0;
    logic [3:0]  load_index = 4'd0;
    logic [31:0] load_value = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic        in_thumb;
    logic [1:0]  status;

    logic [31:0]  core_regs [16];
    logic         core_thumb;
    exec_result_t pending_results [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_left = 0;
    logic hold_request = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;

    thumb_data_processing_execute u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .instruction (instruction),
        .load_index  (load_index),
        .load_value  (load_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .next_pc     (next_pc),
        .reg_written (reg_written),
        .dest_index  (dest_index),
        .dest_value  (dest_value),
        .in_thumb    (in_thumb),
        .status      (status)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] shift_left(input logic [31:0] v, input int unsigned n);
        return (n >= 32) ? 32'd0 : (v << n);
    endfunction

    function automatic logic [31:0] shift_right(input logic [31:0] v, input int unsigned n);
        return (n >= 32) ? 32'd0 : (v >> n);
    endfunction

    function automatic exec_result_t thumb_execute(input logic k, input logic [15:0] ins,
                                                   input logic [3:0] li, input logic [31:0] lv);
        exec_result_t r;
        logic         wr;
        logic         bx;
        logic [3:0]   di;
        logic [3:0]   hd;
        logic [3:0]   hs;
        logic [31:0]  dv;
        logic [31:0]  sv;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  tgt;
        int unsigned  amt;
        status_t      st;
        wr = 1'b0;
        bx = 1'b0;
        di = 4'd0;
        dv = 32'd0;
        tgt = 32'd0;
        st = STATUS_OK;
        if (k)
        begin
            di = li;
            dv = lv;
            core_regs[li] = lv;
            wr = 1'b1;
        end
        else if (!core_thumb)
        begin
            st = STATUS_NOT_THUMB;
        end
        else
        begin
            case (ins[15:13])
                GRP_SHIFT:
                begin
                    sv = core_regs[{1'b0, ins[5:3]}];
                    amt = ins[10:6];
                    case (ins[12:11])
                        SH_LSL: dv = shift_left(sv, amt);
                        SH_LSR: dv = shift_right(sv, (amt == 0) ? 32 : amt);
                        SH_ASR: dv = (amt == 0) ? {32{sv[31]}}
                                                : $unsigned($signed(sv) >>> amt);
                        default:
                        begin
                            b = ins[10] ? {29'd0, ins[8:6]} : core_regs[{1'b0, ins[8:6]}];
                            dv = ins[9] ? (sv - b) : (sv + b);
                        end
                    endcase
                    di = {1'b0, ins[2:0]};
                    wr = 1'b1;
                end
                GRP_IMM8:
                begin
                    if (ins[12:11] != IMM_CMP)
                    begin
                        di = {1'b0, ins[10:8]};
                        wr = 1'b1;
                        case (ins[12:11])
                            IMM_MOV: dv = {24'd0, ins[7:0]};
                            IMM_ADD: dv = core_regs[di] + {24'd0, ins[7:0]};
                            default: dv = core_regs[di] - {24'd0, ins[7:0]};
                        endcase
                    end
                end
                GRP_ALU_HI:
                begin
                    if (ins[12:10] == SUB_ALU)
                    begin
                        a = core_regs[{1'b0, ins[2:0]}];
                        b = core_regs[{1'b0, ins[5:3]}];
                        di = {1'b0, ins[2:0]};
                        wr = 1'b1;
                        case (ins[9:6])
                            ALU_AND: dv = a & b;
                            ALU_EOR: dv = a ^ b;
                            ALU_LSL: dv = shift_left(a, b[7:0]);
                            ALU_LSR: dv = shift_right(a, b[7:0]);
                            ALU_NEG: dv = 32'd0 - b;
                            ALU_ORR: dv = a | b;
                            ALU_BIC: dv = a & ~b;
                            ALU_MVN: dv = ~b;
                            default:
                            begin
                                st = STATUS_UNDEF;
                                wr = 1'b0;
                            end
                        endcase
                    end
                    else if (ins[12:10] == SUB_HI)
                    begin
                        hd = {ins[7], ins[2:0]};
                        hs = {ins[6], ins[5:3]};
                        case (ins[9:8])
                            HI_ADD:
                            begin
                                dv = core_regs[hd] + core_regs[hs];
                                di = hd;
                                wr = 1'b1;
                            end
                            HI_MOV:
                            begin
                                dv = core_regs[hs];
                                di = hd;
                                wr = 1'b1;
                            end
                            HI_BX:
                            begin
                                tgt = core_regs[hs];
                                bx = 1'b1;
                            end
                            default: st = STATUS_UNDEF;
                        endcase
                    end
                    else
                    begin
                        st = STATUS_UNDEF;
                    end
                end
                default: st = STATUS_UNDEF;
            endcase
            if (st == STATUS_OK)
            begin
                if (bx)
                begin
                    core_thumb = tgt[0];
                    core_regs[PC_IDX] = {tgt[31:1], 1'b0};
                end
                else if (wr && di == PC_IDX)
                begin
                    dv[0] = 1'b0;
                    core_regs[PC_IDX] = dv;
                end
                else
                begin
                    if (wr)
                        core_regs[di] = dv;
                    core_regs[PC_IDX] = core_regs[PC_IDX] + 32'd2;
                end
            end
        end
        if (!wr)
        begin
            di = 4'd0;
            dv = 32'd0;
        end
        r.next_pc = core_regs[PC_IDX];
        r.reg_written = wr;
        r.dest_index = di;
        r.dest_value = dv;
        r.thumb = core_thumb;
        r.status = st;
        return r;
    endfunction

    always @(posedge clk)
    begin : result_check
        exec_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                pending_results.push_back(thumb_execute(kind, instruction, load_index,
                                                        load_value));
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("Unexpected result word: pc %h wr %b idx %0d val %h", next_pc,
                                 reg_written, dest_index, dest_value);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (next_pc !== want.next_pc || reg_written !== want.reg_written ||
                        dest_index !== want.dest_index || dest_value !== want.dest_value ||
                        in_thumb !== want.thumb || status !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                        begin
                            $display("Mismatch, expected pc %h wr %b idx %0d val %h thumb %b st %0d",
                                     want.next_pc, want.reg_written, want.dest_index,
                                     want.dest_value, want.thumb, want.status);
                            $display("              got pc %h wr %b idx %0d val %h thumb %b st %0d",
                                     next_pc, reg_written, dest_index, dest_value, in_thumb,
                                     status);
                        end
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall = ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] random_value();
        case ($urandom_range(3))
            0: return $urandom_range(40);
            1: return 32'hFFFFFFFF << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic k, input logic [15:0] ins, input logic [3:0] idx,
                             input logic [31:0] val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        kind = k;
        instruction = ins;
        load_index = idx;
        load_value = val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_reg(input logic [3:0] idx, input logic [31:0] val);
        send_word(1'b1, 16'($urandom), idx, val);
    endtask

    task automatic issue(input logic [15:0] ins);
        send_word(1'b0, ins, 4'($urandom), $urandom);
    endtask

    task automatic send_random_word();
        int          pick;
        logic [31:0] bits;
        logic [15:0] ins;
        logic [3:0]  hs;
        pick = $urandom_range(99);
        bits = $urandom;
        if (pick < 15)
        begin
            load_reg(4'($urandom), random_value());
        end
        else
        begin
            if (pick < 35)
                ins = {GRP_SHIFT, bits[12:0]};
            else if (pick < 50)
                ins = {GRP_IMM8, bits[12:0]};
            else if (pick < 72)
                ins = {GRP_ALU_HI, SUB_ALU, bits[9:0]};
            else if (pick < 90)
                ins = {GRP_ALU_HI, SUB_HI, bits[9:0]};
            else
                ins = bits[15:0];
            // A BX to an even address would leave Thumb mode for the rest of the run.
            if (ins[15:13] == GRP_ALU_HI && ins[12:10] == SUB_HI && ins[9:8] == HI_BX)
            begin
                hs = {ins[6], ins[5:3]};
                if (!core_regs[hs][0])
                    load_reg(hs, random_value() | 32'd1);
            end
            issue(ins);
        end
    endtask

    task automatic test_directed();
        logic [3:0] alu_ops [9];
        alu_ops = '{ALU_AND, ALU_EOR, ALU_LSL, ALU_LSR, ALU_NEG, ALU_ORR, ALU_BIC, ALU_MVN,
                    ALU_ASR};
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        load_reg(4'd0, 32'hFFFFFFFF);
        load_reg(4'd1, 32'h80000000);
        load_reg(4'd2, 32'd33);
        issue({GRP_SHIFT, SH_LSL, 5'd0, 3'd1, 3'd4});
        issue({GRP_SHIFT, SH_LSR, 5'd0, 3'd0, 3'd4});
        issue({GRP_SHIFT, SH_ASR, 5'd0, 3'd1, 3'd5});
        issue({GRP_SHIFT, SH_ADDSUB, 1'b0, 1'b0, 3'd1, 3'd0, 3'd4});
        issue({GRP_SHIFT, SH_ADDSUB, 1'b1, 1'b1, 3'd7, 3'd1, 3'd5});
        issue({GRP_IMM8, IMM_MOV, 3'd7, 8'hFF});
        issue({GRP_IMM8, IMM_CMP, 3'd7, 8'h00});
        issue({GRP_IMM8, IMM_ADD, 3'd0, 8'h01});
        foreach (alu_ops[i])
            issue({GRP_ALU_HI, SUB_ALU, alu_ops[i], (i % 2 == 0) ? 3'd2 : 3'd7, 3'd6});
        issue({GRP_ALU_HI, SUB_HI, HI_ADD, 1'b1, 1'b0, 3'd7, 3'd0});
        issue({GRP_ALU_HI, SUB_HI, HI_MOV, 1'b1, 1'b0, 3'd1, 3'd7});
        issue({GRP_ALU_HI, SUB_HI, HI_CMP, 1'b1, 1'b1, 3'd0, 3'd0});
        issue({GRP_ALU_HI, SUB_HI, HI_BX, 1'b0, 1'b1, 3'd0, 3'd0});
        issue({GRP_LOAD_STORE, 13'h1ABC});
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        tx_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (count)
            send_random_word();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        repeat (100)
            send_random_word();
    endtask

    task automatic test_arm_mode();
        logic [31:0] target;
        tx_idle_pct = 14;
        rx_stall_pct = 14;
        target = random_value() & ~32'd1;
        load_reg(4'd10, target);
        issue({GRP_ALU_HI, SUB_HI, HI_BX, 1'b0, 1'b1, 3'd2, 3'd0});
        repeat (8)
            issue(16'($urandom));
        load_reg(4'($urandom), $urandom);
        repeat (8)
            issue(16'($urandom));
    endtask

    initial
    begin
        foreach (core_regs[i])
            core_regs[i] = 32'd0;
        core_thumb = 1'b1;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_traffic(450, 0, 0);
        test_random_traffic(450, 52, 0);
        test_random_traffic(450, 0, 52);
        test_random_traffic(450, 14, 14);
        test_backpressure();
        test_arm_mode();
        in_valid = 1'b0;
        rx_stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
